// File: rtl/sflc_pkg.sv
// Shared types and codes for the serial frame link controller.
`default_nettype none

package sflc_pkg;

	typedef enum logic [2:0] {
		CMD_ENABLE   = 3'd0,
		CMD_DISABLE  = 3'd1,
		CMD_RX_BYTE  = 3'd2,
		CMD_TIMEOUT  = 3'd3,
		CMD_TRANSMIT = 3'd4,
		CMD_TX_EMPTY = 3'd5,
		CMD_BUF_WR   = 3'd6,
		CMD_RESERVED = 3'd7
	} cmd_t;

	localparam logic [1:0] IRQ_NONE    = 2'd0;
	localparam logic [1:0] IRQ_ENABLE  = 2'd1;
	localparam logic [1:0] IRQ_DISABLE = 2'd2;

	// Buffer accesses for one beat, in full byte addresses.
	typedef struct packed {
		logic       rx_we;
		logic       tx_we;
		logic [7:0] waddr;
		logic [7:0] wdata;
		logic       rd_ok;
		logic [7:0] rd_pos;
		logic       sep;
	} step_req_t;

	// Control and status fields after the step.
	typedef struct packed {
		logic        tx_valid;
		logic        timeout_start;
		logic [1:0]  tx_irq_control;
		logic        driver_disable;
		logic        phy_enable;
		logic [1:0]  link_status;
		logic [8:0]  received_length;
		logic [31:0] rx_frames;
		logic [31:0] tx_frames;
	} step_res_t;

	localparam int unsigned OUT_W = 104;

endpackage

`default_nettype wire

// File: rtl/sflc_step.sv
// Link state machine, counters and buffer access requests for each beat.
`default_nettype none

module sflc_step #(
	parameter int unsigned BUFFER_DEPTH = 256
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic                 cfg_wdata,
	input  wire logic                 fire,
	input  wire logic [2:0]           command,
	input  wire logic [7:0]           data,
	input  wire logic [7:0]           index,
	input  wire logic [7:0]           length,
	output sflc_pkg::step_req_t       req,
	output sflc_pkg::step_res_t       res
);

	typedef enum logic [1:0] {
		ST_DISABLED  = 2'd0,
		ST_RECEIVING = 2'd1,
		ST_COMPLETE  = 2'd2,
		ST_TRANSMIT  = 2'd3
	} link_state_t;

	localparam logic [8:0] DEPTH9 = 9'(BUFFER_DEPTH);

	link_state_t   state_q, state_d;
	logic          sep_q;
	logic [8:0]    rx_count_q, rx_count_d;
	logic [7:0]    tx_total_q, tx_total_d;
	logic [7:0]    tx_position_q, tx_position_d;
	logic [31:0]   rx_frames_q, rx_frames_d;
	logic [31:0]   tx_frames_q, tx_frames_d;
	logic [8:0]    len_sat;
	logic          tx_valid, tmo_start, drv_off, phy_on;
	logic [1:0]    irq;
	sflc_pkg::cmd_t cmd;

	assign cmd     = sflc_pkg::cmd_t'(command);
	assign len_sat = ({1'b0, length} > DEPTH9) ? DEPTH9 : {1'b0, length};

	always_comb begin
		state_d       = state_q;
		rx_count_d    = rx_count_q;
		tx_total_d    = tx_total_q;
		tx_position_d = tx_position_q;
		rx_frames_d   = rx_frames_q;
		tx_frames_d   = tx_frames_q;
		tx_valid      = 1'b0;
		tmo_start     = 1'b0;
		drv_off       = 1'b0;
		phy_on        = 1'b0;
		irq           = sflc_pkg::IRQ_NONE;
		req.rx_we     = 1'b0;
		req.tx_we     = 1'b0;
		req.waddr     = index;
		req.wdata     = data;
		req.rd_pos    = 8'd0;
		req.sep       = sep_q;
		req.rd_ok     = ({1'b0, index} < DEPTH9);
		unique case (cmd)
			sflc_pkg::CMD_ENABLE: begin
				if (state_q == ST_DISABLED) begin
					state_d = ST_RECEIVING;
					phy_on  = 1'b1;
				end
			end
			sflc_pkg::CMD_DISABLE: begin
				state_d = ST_DISABLED;
			end
			sflc_pkg::CMD_RX_BYTE: begin
				if (state_q == ST_RECEIVING) begin
					// store while there is room, restart the timer regardless
					if (rx_count_q < DEPTH9) begin
						req.rx_we  = 1'b1;
						req.waddr  = rx_count_q[7:0];
						rx_count_d = rx_count_q + 9'd1;
					end
					tmo_start = 1'b1;
				end
			end
			sflc_pkg::CMD_TIMEOUT: begin
				if (state_q == ST_TRANSMIT) begin
					drv_off    = 1'b1;
					rx_count_d = 9'd0;
					state_d    = ST_RECEIVING;
				end else if (state_q == ST_RECEIVING && rx_count_q != 9'd0) begin
					rx_frames_d = rx_frames_q + 32'd1;
					state_d     = ST_COMPLETE;
				end
			end
			sflc_pkg::CMD_TRANSMIT: begin
				if (state_q != ST_DISABLED) begin
					if (length != 8'd0) begin
						tx_total_d    = len_sat[7:0];
						state_d       = ST_TRANSMIT;
						tx_position_d = 8'd1;
						tx_valid      = 1'b1;
						irq           = sflc_pkg::IRQ_ENABLE;
						tx_frames_d   = tx_frames_q + 32'd1;
					end else begin
						rx_count_d = 9'd0;
						state_d    = ST_RECEIVING;
					end
				end
			end
			sflc_pkg::CMD_TX_EMPTY: begin
				if (tx_position_q < tx_total_q) begin
					tx_valid      = 1'b1;
					req.rd_pos    = tx_position_q;
					tx_position_d = tx_position_q + 8'd1;
				end else begin
					irq = sflc_pkg::IRQ_DISABLE;
				end
			end
			sflc_pkg::CMD_BUF_WR: begin
				if ({1'b0, index} < DEPTH9) begin
					req.rx_we = ~sep_q;
					req.tx_we = sep_q;
				end
			end
			sflc_pkg::CMD_RESERVED: begin
				state_d = state_q;
			end
			default: begin
				state_d = state_q;
			end
		endcase
	end

	always_comb begin
		res.tx_valid        = tx_valid;
		res.timeout_start   = tmo_start;
		res.tx_irq_control  = irq;
		res.driver_disable  = drv_off;
		res.phy_enable      = phy_on;
		res.link_status     = state_d;
		res.received_length = rx_count_d;
		res.rx_frames       = rx_frames_d;
		res.tx_frames       = tx_frames_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_DISABLED;
			sep_q         <= 1'b0;
			rx_count_q    <= 9'd0;
			tx_total_q    <= 8'd0;
			tx_position_q <= 8'd0;
			rx_frames_q   <= 32'd0;
			tx_frames_q   <= 32'd0;
		end else begin
			if (cfg_we) begin
				sep_q <= cfg_wdata;
			end
			if (fire) begin
				state_q       <= state_d;
				rx_count_q    <= rx_count_d;
				tx_total_q    <= tx_total_d;
				tx_position_q <= tx_position_d;
				rx_frames_q   <= rx_frames_d;
				tx_frames_q   <= tx_frames_d;
			end
		end
	end

	a_rx_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rx_count_q <= DEPTH9)
		else $error("receive count beyond buffer depth");

	a_tx_pos_bound: assert property (@(posedge clk) disable iff (!arst_n)
		tx_position_q <= tx_total_q)
		else $error("transmit position past frame length");

	a_tmo_in_tx: assert property (@(posedge clk) disable iff (!arst_n)
		fire && cmd == sflc_pkg::CMD_TIMEOUT && state_q == ST_TRANSMIT
		|=> state_q == ST_RECEIVING && rx_count_q == 9'd0)
		else $error("timeout while transmitting did not free the receiver");

	a_rx_ignored: assert property (@(posedge clk) disable iff (!arst_n)
		fire && cmd == sflc_pkg::CMD_RX_BYTE && state_q != ST_RECEIVING
		|=> $stable(rx_count_q))
		else $error("byte stored outside the receiving state");

endmodule

`default_nettype wire

// File: rtl/serial_frame_link_controller.sv
// Pipeline: an input beat is registered in the read stage (valid_s1), then in the output register
// that offers it on the master side; a master-side stall can hold it in either register.
// Throughput: one beat per cycle while the output is taken; each beat reads the receive buffer at
// two addresses and the transmit buffer at one, and writes each buffer at most once.
// Back-pressure: input is held off while both the read stage and the output are full and the
// output is not taken. Reset: arst_n clears all control state; then a clearing pass zeroes
// all BUFFER_DEPTH entries of both buffers, with s_axis_tready low (configuration still taken).
`default_nettype none

module serial_frame_link_controller #(
	parameter int unsigned BUFFER_DEPTH = 256
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic        cfg_wdata,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	// [7:0] data, [15:8] index, [23:16] length
	input  wire logic [23:0] s_axis_tdata,
	// [2:0] command
	input  wire logic [2:0]  s_axis_tuser,
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	// [0] tx_valid, [8:1] tx_data, [9] timeout_start, [11:10] tx_irq_control,
	// [12] driver_disable, [13] phy_enable, [21:14] read_data, [23:22] link_status,
	// [32:24] received_length, [64:33] rx_frames, [96:65] tx_frames, [103:97] zero
	output logic [sflc_pkg::OUT_W-1:0] m_axis_tdata
);

	localparam int unsigned AW = $clog2(BUFFER_DEPTH);
	localparam logic [AW-1:0] LAST_ADDR = AW'(BUFFER_DEPTH - 1);

	logic [7:0] rx_mem [BUFFER_DEPTH];
	logic [7:0] tx_mem [BUFFER_DEPTH];

	sflc_pkg::step_req_t req;
	sflc_pkg::step_res_t res;

	logic          accept, advance;
	logic          clr_busy_q;
	logic [AW-1:0] clr_addr_q;

	logic          rx_we, tx_we;
	logic [AW-1:0] rx_wa, tx_wa;
	logic [7:0]    rx_wd, tx_wd;
	logic          fwd;

	logic                valid_s1;
	sflc_pkg::step_res_t res_s1;
	logic                fwd_s1;
	logic [7:0]          fwd_data_s1;
	logic                rd_ok_s1;
	logic                sep_s1;
	logic [7:0]          rx_rda_s1, rx_rdb_s1, tx_rd_s1;

	logic [7:0]                 read_data, tx_data;
	logic [sflc_pkg::OUT_W-1:0] packed_out;
	logic                       out_valid_q;
	logic [sflc_pkg::OUT_W-1:0] out_data_q;

	sflc_step #(
		.BUFFER_DEPTH(BUFFER_DEPTH)
	) u_step (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.fire     (accept),
		.command  (s_axis_tuser),
		.data     (s_axis_tdata[7:0]),
		.index    (s_axis_tdata[15:8]),
		.length   (s_axis_tdata[23:16]),
		.req      (req),
		.res      (res)
	);

	assign advance       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !clr_busy_q && (!valid_s1 || advance);
	assign accept        = s_axis_tvalid && s_axis_tready;

	// clearing pass takes the write ports until both buffers are zero
	assign rx_we = clr_busy_q || (accept && req.rx_we);
	assign rx_wa = clr_busy_q ? clr_addr_q : req.waddr[AW-1:0];
	assign rx_wd = clr_busy_q ? 8'd0 : req.wdata;
	assign tx_we = clr_busy_q || (accept && req.tx_we);
	assign tx_wa = clr_busy_q ? clr_addr_q : req.waddr[AW-1:0];
	assign tx_wd = clr_busy_q ? 8'd0 : req.wdata;

	// readback sees this beat's own write
	assign fwd = req.rx_we && (req.waddr == s_axis_tdata[15:8]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_busy_q) begin
			clr_addr_q <= clr_addr_q + AW'(1);
			if (clr_addr_q == LAST_ADDR) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rx_we) begin
			rx_mem[rx_wa] <= rx_wd;
		end
		if (accept) begin
			rx_rda_s1 <= rx_mem[s_axis_tdata[AW+7:8]];
			rx_rdb_s1 <= rx_mem[req.rd_pos[AW-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (tx_we) begin
			tx_mem[tx_wa] <= tx_wd;
		end
		if (accept) begin
			tx_rd_s1 <= tx_mem[req.rd_pos[AW-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_s1      <= res;
			fwd_s1      <= fwd;
			fwd_data_s1 <= req.wdata;
			rd_ok_s1    <= req.rd_ok;
			sep_s1      <= req.sep;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_comb begin
		read_data = 8'd0;
		if (rd_ok_s1) begin
			read_data = fwd_s1 ? fwd_data_s1 : rx_rda_s1;
		end
		tx_data = 8'd0;
		if (res_s1.tx_valid) begin
			tx_data = sep_s1 ? tx_rd_s1 : rx_rdb_s1;
		end
		packed_out = {7'd0, res_s1.tx_frames, res_s1.rx_frames, res_s1.received_length,
			res_s1.link_status, read_data, res_s1.phy_enable, res_s1.driver_disable,
			res_s1.tx_irq_control, res_s1.timeout_start, tx_data, res_s1.tx_valid};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_data_q <= packed_out;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	a_no_accept_clear: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready |-> !clr_busy_q)
		else $error("input taken during buffer clearing pass");

	a_full_holds_off: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && out_valid_q && !m_axis_tready |-> !s_axis_tready)
		else $error("input taken with both stages full");

	a_accept_loads: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> valid_s1)
		else $error("accepted beat lost before read stage");

endmodule

`default_nettype wire
